// ----- design/bsb_pkg.sv -----
// Shared types and constants for the B-spline span and basis evaluator.
package bsb_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic REG_DEGREE     = 1'b0;
    localparam logic REG_KNOT_COUNT = 1'b1;

    typedef struct packed {
        logic load;
        logic start;
        logic rd_n;
        logic ck_n;
        logic rd_p1;
        logic ck_p1;
        logic bs_test;
        logic bs_ck;
        logic j_init;
        logic rd_l;
        logic rd_r;
        logic cap_r;
        logic mul_r;
        logic mul_l;
        logic div_init;
        logic div_step;
        logic cap_tr;
        logic cap_tl;
        logic upd;
        logic emit;
    } bsb_cmd_t;

    typedef struct packed {
        logic u_ge;
        logic u_lt;
        logic more;
        logic div_done;
        logic last_r;
        logic last_j;
        logic emit_last;
        logic out_free;
    } bsb_sts_t;

endpackage

// ----- design/bsb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bsb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/bsb_ctrl.sv -----
// Sequencing state machine for span search, basis recurrence and result output.
module bsb_ctrl
    import bsb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  logic     operation,
    output logic     s_tready,
    input  bsb_sts_t sts,
    output bsb_cmd_t cmd
);

    typedef enum logic [18:0] {
        S_IDLE    = 19'h00001,
        S_RD_N    = 19'h00002,
        S_CK_N    = 19'h00004,
        S_RD_P1   = 19'h00008,
        S_CK_P1   = 19'h00010,
        S_BS_TEST = 19'h00020,
        S_BS_CK   = 19'h00040,
        S_J_INIT  = 19'h00080,
        S_RD_L    = 19'h00100,
        S_RD_R    = 19'h00200,
        S_CAP_R   = 19'h00400,
        S_MUL_R   = 19'h00800,
        S_DINIT_R = 19'h01000,
        S_DIV_R   = 19'h02000,
        S_MUL_L   = 19'h04000,
        S_DINIT_L = 19'h08000,
        S_DIV_L   = 19'h10000,
        S_UPD     = 19'h20000,
        S_EMIT    = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (operation == OP_EVAL)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_RD_N;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_RD_N:
            begin
                cmd.rd_n   = 1'b1;
                state_next = S_CK_N;
            end
            S_CK_N:
            begin
                cmd.ck_n   = 1'b1;
                state_next = sts.u_ge ? S_J_INIT : S_RD_P1;
            end
            S_RD_P1:
            begin
                cmd.rd_p1  = 1'b1;
                state_next = S_CK_P1;
            end
            S_CK_P1:
            begin
                cmd.ck_p1  = 1'b1;
                state_next = sts.u_lt ? S_J_INIT : S_BS_TEST;
            end
            S_BS_TEST:
            begin
                cmd.bs_test = 1'b1;
                state_next  = sts.more ? S_BS_CK : S_J_INIT;
            end
            S_BS_CK:
            begin
                cmd.bs_ck  = 1'b1;
                state_next = S_BS_TEST;
            end
            S_J_INIT:
            begin
                cmd.j_init = 1'b1;
                state_next = S_RD_L;
            end
            S_RD_L:
            begin
                cmd.rd_l   = 1'b1;
                state_next = S_RD_R;
            end
            S_RD_R:
            begin
                cmd.rd_r   = 1'b1;
                state_next = S_CAP_R;
            end
            S_CAP_R:
            begin
                cmd.cap_r  = 1'b1;
                state_next = S_MUL_R;
            end
            S_MUL_R:
            begin
                cmd.mul_r  = 1'b1;
                state_next = S_DINIT_R;
            end
            S_DINIT_R:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV_R;
            end
            S_DIV_R:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    cmd.cap_tr = 1'b1;
                    state_next = S_MUL_L;
                end
            end
            S_MUL_L:
            begin
                cmd.mul_l  = 1'b1;
                state_next = S_DINIT_L;
            end
            S_DINIT_L:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV_L;
            end
            S_DIV_L:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    cmd.cap_tl = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.upd = 1'b1;
                if (sts.last_r && sts.last_j)
                begin
                    state_next = S_EMIT;
                end
                else if (sts.last_r)
                begin
                    state_next = S_RD_L;
                end
                else
                begin
                    state_next = S_MUL_R;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/bsb_datapath.sv -----
// Datapath: config registers, knot table, search registers, multiplier, divider, output register.
module bsb_datapath
    import bsb_pkg::*;
#(
    parameter int MAX_KNOTS  = 64,
    parameter int MAX_DEGREE = 7,
    parameter int FRAC_BITS  = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  bsb_cmd_t    cmd,
    output bsb_sts_t    sts,
    input  logic [5:0]  knot_index,
    input  logic [15:0] knot_value,
    input  logic [15:0] param_u,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [15:0] basis_value,
    output logic [5:0]  function_index,
    output logic [5:0]  span_index,
    output logic        last
);

    localparam int KAW  = $clog2(MAX_KNOTS);
    localparam int PMAX = (MAX_DEGREE < (MAX_KNOTS - 2) / 2) ? MAX_DEGREE
                                                             : (MAX_KNOTS - 2) / 2;
    localparam int JW   = $clog2(PMAX + 1);
    localparam int VW   = FRAC_BITS + 1;
    localparam int DW   = FRAC_BITS + 2;
    localparam int PW   = 2 * VW;
    localparam int QW   = VW;
    localparam int XW   = (VW > 16) ? VW : 16;
    localparam int CNTW = $clog2(QW + 1);
    localparam logic [VW-1:0] ONE_V = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [XW-1:0] ONE_X = XW'(ONE_V);

    // configuration
    logic [2:0] degree_reg;
    logic [6:0] knot_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg     <= 3'd3;
            knot_count_reg <= 7'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEGREE:     degree_reg     <= cfg_wdata[2:0];
                REG_KNOT_COUNT: knot_count_reg <= cfg_wdata;
                default:        degree_reg     <= degree_reg;
            endcase
        end
    end

    logic [JW-1:0]  p_eff;
    logic [KAW-1:0] n_eff;

    always_comb
    begin
        int d_i;
        int m_i;
        d_i = int'(degree_reg);
        if (d_i < 1)
        begin
            d_i = 1;
        end
        if (d_i > PMAX)
        begin
            d_i = PMAX;
        end
        m_i = int'(knot_count_reg);
        if (m_i < 2 * d_i + 2)
        begin
            m_i = 2 * d_i + 2;
        end
        if (m_i > MAX_KNOTS)
        begin
            m_i = MAX_KNOTS;
        end
        p_eff = JW'(d_i);
        n_eff = KAW'(m_i - d_i - 1);
    end

    // input saturation
    logic [XW-1:0] u_x, kv_x;
    logic [VW-1:0] u_sat, kv_sat;
    logic [15:0]   kidx_w;

    assign u_x    = XW'(param_u);
    assign kv_x   = XW'(knot_value);
    assign u_sat  = (u_x > ONE_X) ? ONE_V : u_x[VW-1:0];
    assign kv_sat = (kv_x > ONE_X) ? ONE_V : kv_x[VW-1:0];
    assign kidx_w = 16'(knot_index);

    // evaluation registers
    logic [VW-1:0]  u_reg;
    logic [JW-1:0]  p_reg;
    logic [KAW-1:0] n_reg;
    logic [KAW-1:0] lo_reg, hi_reg, span_reg;
    logic [JW-1:0]  j_reg, r_reg;
    logic [VW-1:0]  nb_reg  [PMAX+1];
    logic [VW-1:0]  lft_reg [PMAX+1];
    logic [VW-1:0]  rgt_reg [PMAX+1];
    logic [VW-1:0]  carry_reg, tr_reg, tl_reg;
    logic [PW-1:0]  prod_reg;
    logic [DW-1:0]  den_reg;
    logic [DW-1:0]  rem_reg;
    logic [QW-1:0]  acc_reg;
    logic [CNTW-1:0] cnt_reg;

    // knot table
    logic [KAW-1:0] raddr;
    logic [VW-1:0]  rdata;
    logic           ram_we;
    logic [KAW:0]   mid_sum;
    logic [KAW-1:0] mid;

    assign ram_we  = cmd.load && (int'(knot_index) < MAX_KNOTS);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[KAW:1];

    always_comb
    begin
        raddr = '0;
        if (cmd.rd_n)
        begin
            raddr = n_reg;
        end
        else if (cmd.rd_p1)
        begin
            raddr = KAW'(p_reg) + KAW'(1);
        end
        else if (cmd.bs_test)
        begin
            raddr = mid;
        end
        else if (cmd.rd_l)
        begin
            raddr = span_reg + KAW'(1) - KAW'(j_reg);
        end
        else if (cmd.rd_r)
        begin
            raddr = span_reg + KAW'(j_reg);
        end
    end

    bsb_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_KNOTS)
    ) u_knots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (kidx_w[KAW-1:0]),
        .wdata (kv_sat),
        .raddr (raddr),
        .rdata (rdata)
    );

    // recurrence operands
    logic [VW-1:0] nbr, dr, dl, mul_b;
    logic [JW-1:0] r_inc, j_minus_r;
    logic [PW-1:0] num_rnd;
    logic [DW:0]   rem_sh;
    logic          rem_ge;
    logic [VW-1:0] quot;
    logic [VW:0]   upd_sum;
    logic [VW-1:0] upd_sat;

    assign r_inc     = r_reg + JW'(1);
    assign j_minus_r = j_reg - r_reg;
    assign nbr       = nb_reg[r_reg];
    assign dr        = rgt_reg[r_inc];
    assign dl        = lft_reg[j_minus_r];
    assign mul_b     = cmd.mul_l ? dl : dr;
    assign num_rnd   = prod_reg + PW'(den_reg >> 1);
    assign rem_sh    = {rem_reg, acc_reg[QW-1]};
    assign rem_ge    = rem_sh >= {1'b0, den_reg};
    assign quot      = (den_reg == '0) ? '0 : acc_reg;
    assign upd_sum   = {1'b0, carry_reg} + {1'b0, tr_reg};
    assign upd_sat   = (upd_sum > {1'b0, ONE_V}) ? ONE_V : upd_sum[VW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            cnt_reg <= CNTW'(QW);
        end
        else if (cmd.div_step && cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            u_reg <= u_sat;
            p_reg <= p_eff;
            n_reg <= n_eff;
        end
        if (cmd.ck_n && sts.u_ge)
        begin
            span_reg <= n_reg - KAW'(1);
        end
        if (cmd.ck_p1)
        begin
            span_reg <= KAW'(p_reg);
            lo_reg   <= KAW'(p_reg);
            hi_reg   <= n_reg;
        end
        if (cmd.bs_test && !sts.more)
        begin
            span_reg <= lo_reg;
        end
        if (cmd.bs_ck)
        begin
            if (sts.u_lt)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid;
            end
        end
        if (cmd.j_init)
        begin
            nb_reg[0] <= ONE_V;
            j_reg     <= JW'(1);
            r_reg     <= '0;
        end
        if (cmd.rd_r)
        begin
            lft_reg[j_reg] <= (u_reg > rdata) ? (u_reg - rdata) : '0;
        end
        if (cmd.cap_r)
        begin
            rgt_reg[j_reg] <= (rdata > u_reg) ? (rdata - u_reg) : '0;
            r_reg          <= '0;
            carry_reg      <= '0;
        end
        if (cmd.mul_r || cmd.mul_l)
        begin
            prod_reg <= nbr * mul_b;
            den_reg  <= {1'b0, dr} + {1'b0, dl};
        end
        if (cmd.div_init)
        begin
            rem_reg <= DW'(num_rnd >> QW);
            acc_reg <= num_rnd[QW-1:0];
        end
        else if (cmd.div_step && cnt_reg != '0)
        begin
            rem_reg <= rem_ge ? DW'(rem_sh - {1'b0, den_reg}) : DW'(rem_sh);
            acc_reg <= {acc_reg[QW-2:0], rem_ge};
        end
        if (cmd.cap_tr)
        begin
            tr_reg <= quot;
        end
        if (cmd.cap_tl)
        begin
            tl_reg <= quot;
        end
        if (cmd.upd)
        begin
            nb_reg[r_reg] <= upd_sat;
            carry_reg     <= tl_reg;
            if (sts.last_r)
            begin
                nb_reg[j_reg] <= tl_reg;
                j_reg         <= j_reg + JW'(1);
                r_reg         <= '0;
            end
            else
            begin
                r_reg <= r_inc;
            end
        end
        if (cmd.emit)
        begin
            r_reg <= r_inc;
        end
    end

    // output register
    logic [XW-1:0] nb_x;
    logic [15:0]   fidx_w, span_w;
    logic          out_valid_reg;

    assign nb_x   = XW'(nbr);
    assign span_w = 16'(span_reg);
    assign fidx_w = span_w - 16'(p_reg) + 16'(r_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            basis_value    <= nb_x[15:0];
            function_index <= fidx_w[5:0];
            span_index     <= span_w[5:0];
            last           <= (r_reg == p_reg);
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign sts.u_ge      = (u_reg >= rdata);
    assign sts.u_lt      = (u_reg < rdata);
    assign sts.more      = ((hi_reg - lo_reg) > KAW'(1));
    assign sts.div_done  = (cnt_reg == '0);
    assign sts.last_r    = (r_reg == j_reg - JW'(1));
    assign sts.last_j    = (j_reg == p_reg);
    assign sts.emit_last = (r_reg == p_reg);
    assign sts.out_free  = !out_valid_reg || m_tready;

endmodule

// ----- design/bspline_span_and_basis_eval.sv -----
// B-spline knot span search and Cox-de Boor basis evaluation, top level.
//
// Input stream s_*: tuser carries the operation (0 load knot, 1 evaluate).
// A load item writes knot_index/knot_value into the knot table and gives no
// result. An evaluate item searches the knot span for param_u (one table read
// per probe, about log2(knot_count) probes) and then runs the triangular
// recurrence: each of the p(p+1)/2 terms takes two multiply plus
// restoring-divide passes of FRAC_BITS+1 quotient bits each; the divider sets
// the rate.
// Results leave on m_* as degree+1 items, tlast on the final one, one item
// per cycle while the receiver takes them; the result register holds when
// m_tready is low and the block waits. s_tready is high only while idle; the
// last result may still be waiting when the next item is taken.
// User writes configuration on cfg_we/cfg_index/cfg_wdata while idle (not enforced).
// Reset sets degree 3 and knot count 8; knot entries are undefined until loaded.
module bspline_span_and_basis_eval
    import bsb_pkg::*;
#(
    parameter int MAX_KNOTS  = 64,
    parameter int MAX_DEGREE = 7,
    parameter int FRAC_BITS  = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // knot_index[5:0], knot_value[21:6], param_u[37:22]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // basis_value[15:0], function_index[21:16], span_index[27:22]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata
);

    bsb_cmd_t    cmd;
    bsb_sts_t    sts;
    logic [15:0] basis_value;
    logic [5:0]  function_index;
    logic [5:0]  span_index;

    bsb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .operation (s_tuser),
        .s_tready  (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bsb_datapath #(
        .MAX_KNOTS  (MAX_KNOTS),
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .knot_index     (s_tdata[5:0]),
        .knot_value     (s_tdata[21:6]),
        .param_u        (s_tdata[37:22]),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .basis_value    (basis_value),
        .function_index (function_index),
        .span_index     (span_index),
        .last           (m_tlast)
    );

    assign m_tdata = {4'b0, span_index, function_index, basis_value};

`ifndef SYNTH
    // an evaluate item keeps the block busy for at least the next cycle
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == OP_EVAL |=> !s_tready)
        else $error("input taken right after an evaluate item");

    // a non-final result means the evaluation is still in progress
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("idle while a non-final result is pending");

    // the divider is only started from an idle count
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |-> sts.div_done)
        else $error("divider restarted while busy");
`endif

endmodule
